/* sv/thick_line_raster_engine_assert.svh */
// Assertion macros shared by the checker of the thick line raster engine.
// Each macro expands to one labelled concurrent assertion clocked on a rising edge.
// No dependencies.
`ifndef THICK_LINE_RASTER_ENGINE_ASSERT_SVH
`define THICK_LINE_RASTER_ENGINE_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define TLRE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("thick line raster engine check failed");

// Consequent in the cycle after the antecedent.
`define TLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("thick line raster engine check failed");

`endif

/* sv/tlre_pkg.sv */
// Package of the thick line raster engine: sizes, opcodes, register indexes and helpers.
// Used by the top level, its frame store RAM instance and the checker.
// No dependencies.
package tlre_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam int COORD_W = 12;
	localparam int DIM_W   = 8;
	localparam int COLOR_W = 24;
	localparam int THICK_W = 6;
	localparam int OP_W    = 2;
	localparam int RAD_W   = THICK_W - 1;

	localparam int MUL_A_W = COORD_W;
	localparam int MUL_B_W = DIM_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 8'd128;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 8'd96;

	// A configured dimension above the store's size acts as that size.
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
		logic [DIM_W-1:0] res;
		res = v;
		if (32'(v) > lim) begin
			res = DIM_W'(lim);
		end
		return res;
	endfunction

endpackage

/* sv/tlre_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the frame store of the thick line raster engine; no dependencies.
module tlre_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/thick_line_raster_engine.sv */
// Channel   Handshake             Payload
// command   start / busy          op, start_x, start_y, end_x, end_y, thickness, color
// result    done (one cycle)      read_color, status
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A command is taken when start is high and busy low; busy stays high until its result.
// Read: setup, then a registered frame store read. Clear: setup, then one store write a cycle.
// Draw: per line point, each brush row (skipped off frame, else row base, then 2r+1 pixels),
// paced by the shared multiplier and single write port. The result strobe cannot be stalled.
// Reset clears the sequencer and sets the frame size; the store holds rubbish until cleared.
//
// Thick line raster engine top level. Depends on tlre_pkg and tlre_ram.
module thick_line_raster_engine (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [tlre_pkg::OP_W-1:0]               op,
	input  logic signed [tlre_pkg::COORD_W-1:0]     start_x,
	input  logic signed [tlre_pkg::COORD_W-1:0]     start_y,
	input  logic signed [tlre_pkg::COORD_W-1:0]     end_x,
	input  logic signed [tlre_pkg::COORD_W-1:0]     end_y,
	input  logic [tlre_pkg::THICK_W-1:0]            thickness,
	input  logic [tlre_pkg::COLOR_W-1:0]            color,
	output logic                                    done,
	output logic [tlre_pkg::COLOR_W-1:0]            read_color,
	output logic                                    status,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_index,
	input  logic [tlre_pkg::DIM_W-1:0]              cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SETUP = 4'd1;
	localparam logic [3:0] ST_POINT = 4'd2;
	localparam logic [3:0] ST_ROW   = 4'd3;
	localparam logic [3:0] ST_ROWB  = 4'd4;
	localparam logic [3:0] ST_PIX   = 4'd5;
	localparam logic [3:0] ST_STEP  = 4'd6;
	localparam logic [3:0] ST_CLEAR = 4'd7;
	localparam logic [3:0] ST_RADDR = 4'd8;
	localparam logic [3:0] ST_RWAIT = 4'd9;

	localparam int AW = tlre_pkg::ADDR_W;
	localparam int CW = tlre_pkg::CNT_W;

	logic [3:0]                                state_q;
	logic [tlre_pkg::OP_W-1:0]                 op_q;
	logic signed [tlre_pkg::COORD_W-1:0]       cx_q;
	logic signed [tlre_pkg::COORD_W-1:0]       cy_q;
	logic signed [tlre_pkg::COORD_W-1:0]       ex_q;
	logic signed [tlre_pkg::COORD_W-1:0]       ey_q;
	logic [tlre_pkg::RAD_W-1:0]                rad_q;
	logic [tlre_pkg::COLOR_W-1:0]              color_q;
	logic signed [12:0]                        ddx_q;
	logic signed [12:0]                        ddy_q;
	logic                                      stx_neg_q;
	logic                                      sty_neg_q;
	logic signed [14:0]                        err_q;
	logic [9:0]                                r2_q;
	logic [9:0]                                dy2_q;
	logic signed [5:0]                         dx_q;
	logic signed [5:0]                         dy_q;
	logic [AW-1:0]                             rowbase_q;
	logic [AW-1:0]                             addr_q;
	logic [CW-1:0]                             n_q;
	logic [CW-1:0]                             cnt_q;
	logic [tlre_pkg::DIM_W-1:0]                frame_w_q;
	logic [tlre_pkg::DIM_W-1:0]                frame_h_q;
	logic                                      done_q;
	logic [tlre_pkg::COLOR_W-1:0]              read_color_q;
	logic                                      status_q;

	logic [tlre_pkg::DIM_W-1:0]                act_w;
	logic [tlre_pkg::DIM_W-1:0]                act_h;
	logic signed [5:0]                         rad_s;
	logic signed [12:0]                        x_pix;
	logic signed [12:0]                        y_row;
	logic                                      x_in;
	logic                                      y_in;
	logic                                      rd_in;
	logic [5:0]                                dx_mag;
	logic [5:0]                                dy_mag;
	logic [tlre_pkg::MUL_A_W-1:0]              mul_a;
	logic [tlre_pkg::MUL_B_W-1:0]              mul_b;
	logic [tlre_pkg::MUL_P_W-1:0]              mul_p;
	logic                                      pix_hit;
	logic signed [12:0]                        diff_x;
	logic signed [12:0]                        diff_y;
	logic signed [12:0]                        ddx_init;
	logic signed [12:0]                        ddy_init;
	logic signed [15:0]                        e2;
	logic                                      step_x;
	logic                                      step_y;
	logic signed [14:0]                        err_next;
	logic                                      at_end;
	logic                                      ram_we;
	logic [AW-1:0]                             ram_waddr;
	logic                                      ram_re;
	logic [tlre_pkg::COLOR_W-1:0]              ram_rdata;

	assign act_w = tlre_pkg::clamp_dim(frame_w_q, tlre_pkg::MAX_WIDTH);
	assign act_h = tlre_pkg::clamp_dim(frame_h_q, tlre_pkg::MAX_HEIGHT);
	assign rad_s = $signed({1'b0, rad_q});

	assign x_pix = 13'(cx_q) + 13'(dx_q);
	assign y_row = 13'(cy_q) + 13'(dy_q);
	assign x_in  = !x_pix[12] && (x_pix[11:0] < 12'(act_w));
	assign y_in  = !y_row[12] && (y_row[11:0] < 12'(act_h));
	assign rd_in = !cx_q[11] && !cy_q[11] && (cx_q[11:0] < 12'(act_w))
		&& (cy_q[11:0] < 12'(act_h));

	assign dx_mag = dx_q[5] ? 6'(-dx_q) : 6'(dx_q);
	assign dy_mag = dy_q[5] ? 6'(-dy_q) : 6'(dy_q);

	// The one multiplier, shared by every state that needs a product.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SETUP: begin
				case (op_q)
					tlre_pkg::OP_DRAW: begin
						mul_a = tlre_pkg::MUL_A_W'(rad_q);
						mul_b = tlre_pkg::MUL_B_W'(rad_q);
					end
					tlre_pkg::OP_CLEAR: begin
						mul_a = tlre_pkg::MUL_A_W'(act_w);
						mul_b = act_h;
					end
					tlre_pkg::OP_READ: begin
						mul_a = cy_q[11:0];
						mul_b = act_w;
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_ROW: begin
				mul_a = tlre_pkg::MUL_A_W'(dy_mag);
				mul_b = tlre_pkg::MUL_B_W'(dy_mag);
			end
			ST_ROWB: begin
				mul_a = y_row[11:0];
				mul_b = act_w;
			end
			ST_PIX: begin
				mul_a = tlre_pkg::MUL_A_W'(dx_mag);
				mul_b = tlre_pkg::MUL_B_W'(dx_mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = tlre_pkg::MUL_P_W'(mul_a) * tlre_pkg::MUL_P_W'(mul_b);

	assign pix_hit = x_in && ((11'(mul_p[9:0]) + 11'(dy2_q)) <= 11'(r2_q));

	assign diff_x   = 13'(ex_q) - 13'(cx_q);
	assign diff_y   = 13'(ey_q) - 13'(cy_q);
	assign ddx_init = diff_x[12] ? -diff_x : diff_x;
	assign ddy_init = diff_y[12] ? diff_y : -diff_y;

	assign e2       = {err_q, 1'b0};
	assign step_x   = e2 >= 16'(ddy_q);
	assign step_y   = e2 <= 16'(ddx_q);
	assign err_next = err_q + (step_x ? 15'(ddy_q) : 15'sd0) + (step_y ? 15'(ddx_q) : 15'sd0);
	assign at_end   = (cx_q == ex_q) && (cy_q == ey_q);

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_PIX) && pix_hit);
	assign ram_waddr = (state_q == ST_CLEAR) ? cnt_q[AW-1:0]
		: rowbase_q + AW'(x_pix[11:0]);
	assign ram_re    = (state_q == ST_RADDR);

	tlre_ram #(
		.DATA_W (tlre_pkg::COLOR_W),
		.DEPTH  (tlre_pkg::STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (color_q),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			frame_w_q <= tlre_pkg::FRAME_WIDTH_RST;
			frame_h_q <= tlre_pkg::FRAME_HEIGHT_RST;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == tlre_pkg::REG_FRAME_WIDTH) begin
					frame_w_q <= cfg_data;
				end else begin
					frame_h_q <= cfg_data;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					case (op_q)
						tlre_pkg::OP_DRAW: begin
							state_q <= ST_POINT;
						end
						tlre_pkg::OP_CLEAR: begin
							if (CW'(mul_p) == '0) begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= ST_CLEAR;
							end
						end
						tlre_pkg::OP_READ: begin
							if (rd_in) begin
								state_q <= ST_RADDR;
							end else begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				ST_POINT: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (y_in) begin
						state_q <= ST_ROWB;
					end else if (dy_q == rad_s) begin
						state_q <= ST_STEP;
					end
				end
				ST_ROWB: begin
					state_q <= ST_PIX;
				end
				ST_PIX: begin
					if (dx_q == rad_s) begin
						state_q <= (dy_q == rad_s) ? ST_STEP : ST_ROW;
					end
				end
				ST_STEP: begin
					if (at_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_POINT;
					end
				end
				ST_CLEAR: begin
					if ((cnt_q + CW'(1)) == n_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RADDR: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q    <= op;
					cx_q    <= start_x;
					cy_q    <= start_y;
					ex_q    <= end_x;
					ey_q    <= end_y;
					rad_q   <= (thickness > 6'd1) ? thickness[5:1] : '0;
					color_q <= color;
				end
			end
			ST_SETUP: begin
				read_color_q <= '0;
				status_q     <= (op_q == tlre_pkg::OP_READ) && !rd_in;
				r2_q         <= mul_p[9:0];
				n_q          <= CW'(mul_p);
				cnt_q        <= '0;
				addr_q       <= AW'(mul_p) + AW'(cx_q[11:0]);
				ddx_q        <= ddx_init;
				ddy_q        <= ddy_init;
				stx_neg_q    <= diff_x[12] || (diff_x == '0);
				sty_neg_q    <= diff_y[12] || (diff_y == '0);
				err_q        <= 15'(ddx_init) + 15'(ddy_init);
			end
			ST_POINT: begin
				dy_q <= -rad_s;
			end
			ST_ROW: begin
				if (y_in) begin
					dy2_q <= mul_p[9:0];
				end else if (dy_q != rad_s) begin
					dy_q <= dy_q + 6'sd1;
				end
			end
			ST_ROWB: begin
				rowbase_q <= AW'(mul_p);
				dx_q      <= -rad_s;
			end
			ST_PIX: begin
				if (dx_q == rad_s) begin
					if (dy_q != rad_s) begin
						dy_q <= dy_q + 6'sd1;
					end
				end else begin
					dx_q <= dx_q + 6'sd1;
				end
			end
			ST_STEP: begin
				if (!at_end) begin
					err_q <= err_next;
					if (step_x) begin
						cx_q <= stx_neg_q ? cx_q - 12'sd1 : cx_q + 12'sd1;
					end
					if (step_y) begin
						cy_q <= sty_neg_q ? cy_q - 12'sd1 : cy_q + 12'sd1;
					end
				end
			end
			ST_CLEAR: begin
				cnt_q <= cnt_q + CW'(1);
			end
			ST_RWAIT: begin
				read_color_q <= ram_rdata;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign read_color = read_color_q;
	assign status     = status_q;
	assign cfg_ready  = 1'b1;

endmodule

/* sv/tlre_checker.sv */
// Port-level checker for the thick line raster engine, bound to the top level below.
// Depends on tlre_pkg and thick_line_raster_engine_assert.svh.
`include "thick_line_raster_engine_assert.svh"

module tlre_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic                               status,
	input logic [tlre_pkg::COLOR_W-1:0]       read_color
);

	`TLRE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TLRE_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`TLRE_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`TLRE_ASSERT_SAME(a_status_zero, clk, arst_n, done && status, read_color == '0)
	`TLRE_ASSERT_NEXT(a_no_spurious, clk, arst_n, !busy && !done, !done)

endmodule

bind thick_line_raster_engine tlre_checker u_tlre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.read_color (read_color)
);
